/* hdl/registered_handle_fifo_core_defines.svh */
// Assertion macros for the registered handle FIFO core.
`ifndef REGISTERED_HANDLE_FIFO_CORE_DEFINES_SVH
`define REGISTERED_HANDLE_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RHF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("registered handle fifo: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("registered handle fifo: next-cycle check failed");

`endif

/* hdl/rhf_pkg.sv */
// Shared types and constants for the registered handle FIFO.
`timescale 1ns / 1ps
package rhf_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE    = 2'd0,
    OP_DEQUEUE    = 2'd1,
    OP_REGISTER   = 2'd2,
    OP_UNREGISTER = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_REG_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_APPLY  = 2'd2,
    S_RESULT = 2'd3
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } qcell_ctl_t;

endpackage

/* hdl/rhf_qcell.sv */
// One queue cell: holds a handle, loads a new one or takes its neighbor's.
`timescale 1ns / 1ps
module rhf_qcell #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  rhf_pkg::qcell_ctl_t ctl,
  input  logic [WIDTH-1:0]   nbr_data,
  input  logic [WIDTH-1:0]   load_data,
  output logic [WIDTH-1:0]   data
);
  import rhf_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= nbr_data;
    end
  end

endmodule

/* hdl/rhf_rcell.sv */
// One registry cell: a handle with its valid bit, rotated along the ring.
`timescale 1ns / 1ps
module rhf_rcell #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             nbr_valid,
  input  logic [WIDTH-1:0] nbr_data,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= nbr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nbr_data;
    end
  end

endmodule

/* hdl/registered_handle_fifo_core.sv */
// Top level of the registered handle FIFO: control sequencer, cell rows and output register.
// Items enter on the in channel (in_valid, in_stall, operation, buffer_id) and each item
// yields exactly one result on the out channel (out_valid, out_stall, status, out_buffer_id,
// queue_count, queue_empty). cfg_ready is always high. The user must write the capacity
// register over cfg_valid / cfg_ready / capacity only while the block is idle; the block
// itself does not enforce it. One item is worked on at a time. Dequeue and an enqueue
// into a full queue go from acceptance through the apply and result states back to idle.
// Enqueue and register rotate the registry ring of cells once, one cell per cycle, in the
// scan state. Unregister rotates the registry while the queue cells rotate their entries
// through the head comparator, and stays in the scan state until both are done.
// Each ring has a single head comparator.
// Reset empties the queue, clears every registry valid bit and sets capacity to 16.
// When the receiver stalls, a finished result waits in the output register and the block
// holds the next result until that register is free; the input is stalled meanwhile.
`timescale 1ns / 1ps
`include "registered_handle_fifo_core_defines.svh"
module registered_handle_fifo_core #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int REGISTRY_DEPTH = 16,
  parameter int ID_BITS        = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rhf_pkg::OP_W-1:0]      operation,
  input  logic [rhf_pkg::ID_W-1:0]      buffer_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rhf_pkg::STATUS_W-1:0]  status,
  output logic [rhf_pkg::ID_W-1:0]      out_buffer_id,
  output logic [rhf_pkg::COUNT_W-1:0]   queue_count,
  output logic                          queue_empty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rhf_pkg::CAP_W-1:0]     capacity
);
  import rhf_pkg::*;

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RIW  = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C   = CMPW'(QUEUE_DEPTH);
  localparam logic [RIW-1:0]  SCAN_LAST = RIW'(REGISTRY_DEPTH - 1);

  state_t               state, state_next;
  op_t                  op_r, in_op;
  logic [ID_BITS-1:0]   id_r;
  logic [CAP_W-1:0]     cap_r;
  logic [CW-1:0]        fill, fill_next;
  logic [CW-1:0]        purge_left, purge_left_next;
  logic [RIW-1:0]       scan_cnt, scan_cnt_next;
  logic                 found, found_next;
  logic                 done, done_next;
  status_t              res_status, res_status_next;
  logic [ID_BITS-1:0]   taken, taken_next;

  logic                 accept;
  logic                 load_out;
  logic [CMPW-1:0]      cap_ext, fill_ext;
  logic                 q_full;
  logic                 purge_active;
  logic                 head_match_r, head_match_q;

  logic [ID_BITS-1:0]   qdata [QUEUE_DEPTH];
  qcell_ctl_t           qctl  [QUEUE_DEPTH];
  logic                 q_shift, q_load;
  logic [QIW-1:0]       q_wr_idx;
  logic [ID_BITS-1:0]   q_load_data;

  logic                 rvalid [REGISTRY_DEPTH];
  logic [ID_BITS-1:0]   rdata  [REGISTRY_DEPTH];
  logic                 r_shift;
  logic                 wrap_valid;
  logic [ID_BITS-1:0]   wrap_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_op     = op_t'(operation);

  assign cap_ext  = CMPW'(cap_r);
  assign fill_ext = CMPW'(fill);
  assign q_full   = (cap_r == '0) ? (fill_ext >= CMPW'(1)) :
                    (cap_ext > DEPTH_C) ? (fill_ext >= DEPTH_C) : (fill_ext >= cap_ext);

  assign purge_active = (purge_left != '0);
  assign head_match_r = rvalid[0] && (rdata[0] == id_r);
  assign head_match_q = (qdata[0] == id_r);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_queue
      logic [ID_BITS-1:0] nbr;
      if (gi < QUEUE_DEPTH - 1) begin : g_mid
        assign nbr = qdata[gi + 1];
      end else begin : g_last
        assign nbr = qdata[gi];
      end
      assign qctl[gi].shift = q_shift;
      assign qctl[gi].load  = q_load && (q_wr_idx == QIW'(gi));
      rhf_qcell #(.WIDTH(ID_BITS)) u_qcell (
        .clk       (clk),
        .ctl       (qctl[gi]),
        .nbr_data  (nbr),
        .load_data (q_load_data),
        .data      (qdata[gi])
      );
    end

    for (gi = 0; gi < REGISTRY_DEPTH; gi++) begin : g_registry
      logic               nbr_v;
      logic [ID_BITS-1:0] nbr_d;
      if (gi < REGISTRY_DEPTH - 1) begin : g_mid
        assign nbr_v = rvalid[gi + 1];
        assign nbr_d = rdata[gi + 1];
      end else begin : g_last
        assign nbr_v = wrap_valid;
        assign nbr_d = wrap_data;
      end
      rhf_rcell #(.WIDTH(ID_BITS)) u_rcell (
        .clk       (clk),
        .rst       (rst),
        .shift     (r_shift),
        .nbr_valid (nbr_v),
        .nbr_data  (nbr_d),
        .valid     (rvalid[gi]),
        .data      (rdata[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    purge_left_next = purge_left;
    scan_cnt_next   = scan_cnt;
    found_next      = found;
    done_next       = done;
    res_status_next = res_status;
    taken_next      = taken;
    q_shift         = 1'b0;
    q_load          = 1'b0;
    q_wr_idx        = QIW'(fill);
    q_load_data     = id_r;
    r_shift         = 1'b0;
    wrap_valid      = rvalid[0];
    wrap_data       = rdata[0];
    load_out        = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          scan_cnt_next   = '0;
          found_next      = 1'b0;
          done_next       = 1'b0;
          purge_left_next = (in_op == OP_UNREGISTER) ? fill : '0;
          case (in_op)
            OP_ENQUEUE: state_next = q_full ? S_APPLY : S_SCAN;
            OP_DEQUEUE: state_next = S_APPLY;
            default:    state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        r_shift = 1'b1;
        case (op_r)
          OP_ENQUEUE: begin
            if (head_match_r) begin
              found_next = 1'b1;
            end
          end
          OP_REGISTER: begin
            if (!rvalid[0] && !done) begin
              wrap_valid = 1'b1;
              wrap_data  = id_r;
              done_next  = 1'b1;
            end
          end
          OP_UNREGISTER: begin
            if (head_match_r && !done) begin
              wrap_valid = 1'b0;
              done_next  = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (scan_cnt != SCAN_LAST) begin
          scan_cnt_next = scan_cnt + 1'b1;
        end
        // The head entry leaves the queue and returns at the tail unless it matches.
        if (purge_active) begin
          q_shift         = 1'b1;
          purge_left_next = purge_left - 1'b1;
          if (!head_match_q) begin
            q_load      = 1'b1;
            q_wr_idx    = QIW'(fill - 1'b1);
            q_load_data = qdata[0];
          end else begin
            fill_next = fill - 1'b1;
          end
        end
        if ((scan_cnt == SCAN_LAST) && !purge_active) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next      = S_RESULT;
        taken_next      = '0;
        res_status_next = ST_OK;
        case (op_r)
          OP_ENQUEUE: begin
            if (q_full) begin
              res_status_next = ST_FULL;
            end else if (!found) begin
              res_status_next = ST_UNKNOWN;
            end else begin
              q_load    = 1'b1;
              fill_next = fill + 1'b1;
            end
          end
          OP_DEQUEUE: begin
            if (fill == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              taken_next = qdata[0];
              q_shift    = 1'b1;
              fill_next  = fill - 1'b1;
            end
          end
          OP_REGISTER: begin
            if (!done) begin
              res_status_next = ST_REG_FULL;
            end
          end
          default: begin
          end
        endcase
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      purge_left <= '0;
      scan_cnt   <= '0;
      found      <= 1'b0;
      done       <= 1'b0;
      cap_r      <= CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      fill       <= fill_next;
      purge_left <= purge_left_next;
      scan_cnt   <= scan_cnt_next;
      found      <= found_next;
      done       <= done_next;
      if (cfg_valid && cfg_ready) begin
        cap_r <= capacity;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      id_r <= ID_BITS'(buffer_id);
    end
    res_status <= res_status_next;
    taken      <= taken_next;
    if (load_out) begin
      status        <= res_status;
      out_buffer_id <= ID_W'(taken);
      queue_count   <= COUNT_W'(fill);
      queue_empty   <= (fill == '0);
    end
  end

  `RHF_ASSERT_NEXT(a_enqueue_grows, (state == S_APPLY) && (op_r == OP_ENQUEUE) && (res_status_next == ST_OK), fill == $past(fill) + 1'b1)
  `RHF_ASSERT_NEXT(a_purge_never_grows, state == S_SCAN, fill <= $past(fill))
  `RHF_ASSERT_IMPLY(a_fill_bounded, 1'b1, fill_ext <= DEPTH_C)
  `RHF_ASSERT_NEXT(a_empty_dequeue_zero, load_out && (res_status == ST_EMPTY), out_buffer_id == '0)

endmodule

/* dv/tb.sv */
// Self-checking testbench for the registered handle FIFO core.
`timescale 1ns / 1ps
module tb;
  import rhf_pkg::*;

  localparam int QDEPTH = 16;
  localparam int RDEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 90;

  typedef struct packed {
    status_t             st;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  cnt;
    logic                empty;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    op_t              op;
    logic [ID_W-1:0]  arg;
    logic             has_want;
    result_t          want;
  } stim_row_t;

  localparam result_t NO_WANT = '{ST_OK, 8'd0, 5'd0, 1'b0};

  localparam stim_row_t DIRECTED [26] = '{
    '{ROW_ITEM, OP_DEQUEUE,    8'd0,   1'b1, '{ST_EMPTY,   8'd0,   5'd0, 1'b1}},
    '{ROW_ITEM, OP_ENQUEUE,    8'd255, 1'b1, '{ST_UNKNOWN, 8'd0,   5'd0, 1'b1}},
    '{ROW_ITEM, OP_UNREGISTER, 8'd7,   1'b1, '{ST_OK,      8'd0,   5'd0, 1'b1}},
    '{ROW_ITEM, OP_REGISTER,   8'd255, 1'b0, NO_WANT},
    '{ROW_ITEM, OP_REGISTER,   8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_REGISTER,   8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd255, 1'b1, '{ST_OK,      8'd0,   5'd1, 1'b0}},
    '{ROW_ITEM, OP_ENQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd255, 1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_UNREGISTER, 8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_CFG,  OP_ENQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd255, 1'b1, '{ST_FULL,    8'd0,   5'd3, 1'b0}},
    '{ROW_ITEM, OP_DEQUEUE,    8'd0,   1'b1, '{ST_OK,      8'd255, 5'd2, 1'b0}},
    '{ROW_CFG,  OP_ENQUEUE,    8'd31,  1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd255, 1'b0, NO_WANT},
    '{ROW_CFG,  OP_ENQUEUE,    8'd2,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd0,   1'b1, '{ST_FULL,    8'd0,   5'd3, 1'b0}},
    '{ROW_ITEM, OP_DEQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_UNREGISTER, 8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_ENQUEUE,    8'd0,   1'b0, NO_WANT},
    '{ROW_ITEM, OP_UNREGISTER, 8'd255, 1'b0, NO_WANT},
    '{ROW_ITEM, OP_DEQUEUE,    8'hA5,  1'b1, '{ST_EMPTY,   8'd0,   5'd0, 1'b1}},
    '{ROW_CFG,  OP_ENQUEUE,    8'd16,  1'b0, NO_WANT}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = '0;
  logic [ID_W-1:0]     buffer_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_buffer_id;
  logic [COUNT_W-1:0]  queue_count;
  logic                queue_empty;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    capacity = '0;

  registered_handle_fifo_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .buffer_id(buffer_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_buffer_id(out_buffer_id),
    .queue_count(queue_count), .queue_empty(queue_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity)
  );

  always #10 clk = ~clk;

  logic [ID_W-1:0]  held_handles [$];
  logic [ID_W-1:0]  known_id [RDEPTH];
  logic             known_ok [RDEPTH];
  logic [CAP_W-1:0] cap_setting = CAP_RESET;
  result_t          pending_results [$];
  int               errors = 0;
  int               quiet = 0;
  int               stall_left = 0;
  bit               idle_on = 1'b1;

  function automatic int find_known(logic [ID_W-1:0] id);
    for (int i = 0; i < RDEPTH; i++) begin
      if (known_ok[i] && known_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic result_t handle_fifo_step(op_t op, logic [ID_W-1:0] id);
    result_t r;
    int cap_eff;
    int slot;
    logic [ID_W-1:0] kept [$];
    r = NO_WANT;
    cap_eff = (cap_setting == 0) ? 1 : (cap_setting > QDEPTH) ? QDEPTH : int'(cap_setting);
    case (op)
      OP_ENQUEUE: begin
        if (held_handles.size() >= cap_eff) r.st = ST_FULL;
        else if (find_known(id) < 0) r.st = ST_UNKNOWN;
        else held_handles.push_back(id);
      end
      OP_DEQUEUE: begin
        if (held_handles.size() == 0) r.st = ST_EMPTY;
        else r.id = held_handles.pop_front();
      end
      OP_REGISTER: begin
        slot = -1;
        for (int i = RDEPTH - 1; i >= 0; i--) begin
          if (!known_ok[i]) slot = i;
        end
        if (slot < 0) begin
          r.st = ST_REG_FULL;
        end else begin
          known_id[slot] = id;
          known_ok[slot] = 1'b1;
        end
      end
      default: begin
        slot = find_known(id);
        if (slot >= 0) known_ok[slot] = 1'b0;
        foreach (held_handles[i]) begin
          if (held_handles[i] != id) kept.push_back(held_handles[i]);
        end
        held_handles = kept;
      end
    endcase
    r.cnt = COUNT_W'(held_handles.size());
    r.empty = (held_handles.size() == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(op_t op, logic [ID_W-1:0] id, logic has_want, result_t want);
    int gap;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    buffer_id <= id;
    do @(posedge clk); while (in_stall);
    pred = handle_fifo_step(op, id);
    pending_results.push_back(has_want ? want : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    drain_results();
    cfg_valid <= 1'b1;
    capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    cap_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on) begin
      stall_left = pick_gap();
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item status %0d id %0d count %0d empty %0d",
                 $time, status, out_buffer_id, queue_count, queue_empty);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (want.st != status || want.id != out_buffer_id || want.cnt != queue_count ||
            want.empty != queue_empty) begin
          errors++;
          $display("%0t: expected status %0d id %0d count %0d empty %0d", $time,
                   want.st, want.id, want.cnt, want.empty);
          $display("%0t: actual   status %0d id %0d count %0d empty %0d", $time,
                   status, out_buffer_id, queue_count, queue_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [ID_W-1:0] pool [5];
    logic [CAP_W-1:0] phase_cap [RAND_PHASES];
    int r;
    int reg_pct;
    int unreg_pct;
    op_t op;
    logic [ID_W-1:0] id;
    for (int i = 0; i < RDEPTH; i++) begin
      known_id[i] = '0;
      known_ok[i] = 1'b0;
    end
    phase_cap = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd10, 5'd21, 5'd3};
    phase_cap[RAND_PHASES - 1] = CAP_W'($urandom_range(0, 31));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) write_capacity(DIRECTED[i].arg[CAP_W-1:0]);
      else send_item(DIRECTED[i].op, DIRECTED[i].arg, DIRECTED[i].has_want, DIRECTED[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph % 3 != 2);
      reg_pct = (ph % 2 == 1) ? 25 : 12;
      unreg_pct = (ph % 2 == 1) ? 10 : 23;
      foreach (pool[k]) pool[k] = ID_W'($urandom_range(0, 255));
      write_capacity(phase_cap[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) op = OP_ENQUEUE;
        else if (r < 100 - reg_pct - unreg_pct) op = OP_DEQUEUE;
        else if (r < 100 - unreg_pct) op = OP_REGISTER;
        else op = OP_UNREGISTER;
        if ($urandom_range(0, 99) < 85) id = pool[$urandom_range(0, 4)];
        else id = ID_W'($urandom_range(0, 255));
        send_item(op, id, 1'b0, NO_WANT);
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
